// ===== hdl/kcl_pkg.sv =====
// kcl_pkg: shared types, constants and the key label table of the keypad code lock.
// No dependencies; every other file takes its names from here by scoped reference.
`timescale 1ns / 1ps

package kcl_pkg;

  // Number of keys in one code
  localparam int CODE_LENGTH = 4;
  localparam int DIGIT_W     = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(CODE_LENGTH - 1);

  // Register reset values and the shortest lockout
  localparam logic [7:0] LOCKOUT_TICKS_RST = 8'd10;
  localparam logic [3:0] MAX_FAILURES_RST  = 4'd3;
  localparam logic [7:0] MIN_LOCKOUT       = 8'd1;

  // Register indexes on the config port
  typedef enum logic [0:0] {
    REG_LOCKOUT_TICKS = 1'b0,
    REG_MAX_FAILURES  = 1'b1
  } reg_idx_t;

  // Input kinds
  typedef enum logic [0:0] {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Lock modes; the spare code behaves like entry mode
  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_ENTRY  = 2'd1,
    MODE_LOCKED = 2'd2
  } mode_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_STORED   = 3'd1,
    ST_OK       = 3'd2,
    ST_FAIL     = 3'd3,
    ST_LOCKED   = 3'd4,
    ST_UNLOCKED = 3'd5
  } status_t;

  // One input item
  typedef struct packed {
    op_t        op;
    logic [3:0] key;
  } item_t;

  // One result item
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    status_t    status;
    logic [7:0] lock_remaining;
  } result_t;

  // Raw key code to ASCII label: 7 4 1 0 8 5 2 0 9 6 3 = / * - +
  localparam logic [7:0] KEY_LABEL [16] = '{
    8'h37, 8'h34, 8'h31, 8'h30, 8'h38, 8'h35, 8'h32, 8'h30,
    8'h39, 8'h36, 8'h33, 8'h3d, 8'h2f, 8'h2a, 8'h2d, 8'h2b
  };

endpackage

// ===== hdl/kcl_in_reg.sv =====
// kcl_in_reg: input register of the keypad code lock, one beat deep.
// Depends on kcl_pkg for the item type.
`timescale 1ns / 1ps

module kcl_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  kcl_pkg::item_t in_item,
  input  logic           advance,   // held beat is consumed this cycle
  output logic           item_valid,
  output kcl_pkg::item_t item
);

  logic           valid_r, valid_nxt;
  kcl_pkg::item_t item_r;

  // Take a new beat when empty or when the held one moves on
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/kcl_core.sv =====
// kcl_core: lock state, config registers and the per-beat next-state/result logic.
// Depends on kcl_pkg for types, the label table and code length.
`timescale 1ns / 1ps

module kcl_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic [0:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            step,      // process item this cycle
  input  kcl_pkg::item_t  item,
  output kcl_pkg::result_t result
);

  localparam int N = kcl_pkg::CODE_LENGTH;
  localparam int W = kcl_pkg::DIGIT_W;

  // Config registers
  logic [7:0] lockout_ticks_r;
  logic [3:0] max_failures_r;

  // Lock state
  kcl_pkg::mode_t mode_r, mode_nxt;
  logic [W-1:0]   digit_cnt_r, digit_cnt_nxt;
  logic [3:0]     fail_cnt_r, fail_cnt_nxt;
  logic [7:0]     lock_timer_r, lock_timer_nxt;
  logic [7:0]     stored_code_r [N];
  logic [7:0]     entry_buf_r   [N];

  logic [7:0] label;
  logic       last_key;
  logic       code_match;
  logic [3:0] fail_inc;
  logic [7:0] timer_load;
  logic       wr_stored;
  logic       wr_entry;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_ticks_r <= kcl_pkg::LOCKOUT_TICKS_RST;
      max_failures_r  <= kcl_pkg::MAX_FAILURES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kcl_pkg::REG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_data;
        kcl_pkg::REG_MAX_FAILURES:  max_failures_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign label    = kcl_pkg::KEY_LABEL[item.key];
  assign last_key = (digit_cnt_r == kcl_pkg::LAST_DIGIT);
  assign fail_inc = fail_cnt_r + 4'd1;
  assign timer_load = (lockout_ticks_r != 8'd0) ? lockout_ticks_r : kcl_pkg::MIN_LOCKOUT;

  // Earlier keys come from the buffer, the final one is the current label
  always_comb begin
    code_match = (label == stored_code_r[N-1]);
    for (int i = 0; i < N - 1; i++) begin
      if (entry_buf_r[i] != stored_code_r[i]) begin
        code_match = 1'b0;
      end
    end
  end

  // Next state and result
  always_comb begin
    mode_nxt       = mode_r;
    digit_cnt_nxt  = digit_cnt_r;
    fail_cnt_nxt   = fail_cnt_r;
    lock_timer_nxt = lock_timer_r;
    wr_stored      = 1'b0;
    wr_entry       = 1'b0;
    result         = '0;
    result.status  = kcl_pkg::ST_NONE;

    case (mode_r)
      kcl_pkg::MODE_LOCKED: begin
        result.status = kcl_pkg::ST_LOCKED;
        result.lock_remaining = lock_timer_r;
        if (item.op == kcl_pkg::OP_TICK) begin
          if (lock_timer_r > 8'd1) begin
            lock_timer_nxt        = lock_timer_r - 8'd1;
            result.lock_remaining = lock_timer_r - 8'd1;
          end else begin
            lock_timer_nxt        = 8'd0;
            mode_nxt              = kcl_pkg::MODE_ENTRY;
            result.status         = kcl_pkg::ST_UNLOCKED;
            result.lock_remaining = 8'd0;
          end
        end
      end
      kcl_pkg::MODE_SET: begin
        if (item.op == kcl_pkg::OP_KEY) begin
          wr_stored         = 1'b1;
          result.echo_valid = 1'b1;
          result.echo_char  = label;
          if (last_key) begin
            digit_cnt_nxt = '0;
            mode_nxt      = kcl_pkg::MODE_ENTRY;
            result.status = kcl_pkg::ST_STORED;
          end else begin
            digit_cnt_nxt = digit_cnt_r + W'(1);
          end
        end
      end
      default: begin
        // entry mode, and the spare mode code
        if (item.op == kcl_pkg::OP_KEY) begin
          wr_entry          = 1'b1;
          result.echo_valid = 1'b1;
          result.echo_char  = label;
          if (last_key) begin
            digit_cnt_nxt = '0;
            if (code_match) begin
              result.status = kcl_pkg::ST_OK;
            end else if (fail_inc >= max_failures_r) begin
              fail_cnt_nxt          = 4'd0;
              mode_nxt              = kcl_pkg::MODE_LOCKED;
              lock_timer_nxt        = timer_load;
              result.status         = kcl_pkg::ST_LOCKED;
              result.lock_remaining = timer_load;
            end else begin
              fail_cnt_nxt  = fail_inc;
              result.status = kcl_pkg::ST_FAIL;
            end
          end else begin
            digit_cnt_nxt = digit_cnt_r + W'(1);
          end
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= kcl_pkg::MODE_SET;
      digit_cnt_r  <= '0;
      fail_cnt_r   <= 4'd0;
      lock_timer_r <= 8'd0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
      lock_timer_r <= lock_timer_nxt;
    end
  end

  // Code and entry stores; always written before they are compared
  always_ff @(posedge clk) begin
    if (step && wr_stored) begin
      stored_code_r[digit_cnt_r] <= label;
    end
    if (step && wr_entry) begin
      entry_buf_r[digit_cnt_r] <= label;
    end
  end

endmodule

// ===== hdl/kcl_out_reg.sv =====
// kcl_out_reg: result register of the keypad code lock.
// Depends on kcl_pkg for the result type.
`timescale 1ns / 1ps

module kcl_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,   // register free to load this cycle
  input  kcl_pkg::result_t res,
  output logic             out_tvalid,
  input  logic             out_tready,
  output kcl_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  kcl_pkg::result_t res_r;

  assign res_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

// ===== hdl/keypad_code_lock_top.sv =====
// keypad_code_lock_top: keypad code lock, input register, lock core, result register.
// Depends on kcl_pkg, kcl_in_reg, kcl_core and kcl_out_reg.
//
//   channel  direction  handshake          payload
//   in_      slave      tvalid / tready    tuser op, tdata key
//   out_     master     tvalid / tready    tuser echo_valid, tdata char/status/remaining
//   cfg_     slave      valid / ready      index, data (ready tied high)
//
// One beat per cycle sustained while out_ is not stalled; each beat passes through the input and result registers.
// The lock state is updated in the cycle a beat moves from the input register into
// the result register, so throughput is set by that single registered step.
// A stall on out_ holds the result register and backs up through the input register.
// rst_n is synchronous: set-code mode, counters zero, registers to 10 and 3.
`timescale 1ns / 1ps

module keypad_code_lock_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] key, [7:4] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] echo_char, [10:8] status, [18:11] lock_remaining,
                                  // [23:19] zero
  output logic        out_tuser,  // [0] echo_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  kcl_pkg::item_t   in_item, item;
  kcl_pkg::result_t res, out_res;
  logic             item_valid;
  logic             res_ready;
  logic             step;

  assign in_item.op  = kcl_pkg::op_t'(in_tuser);
  assign in_item.key = in_tdata[3:0];
  assign cfg_ready   = 1'b1;
  assign step        = item_valid && res_ready;

  kcl_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  kcl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .result    (res)
  );

  kcl_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (item_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Result beat packing
  assign out_tuser = out_res.echo_valid;
  assign out_tdata = {5'd0, out_res.lock_remaining, out_res.status, out_res.echo_char};

endmodule

// ===== hdl/kcl_checker.sv =====
// kcl_port_checker: port-level assertions for keypad_code_lock_top, attached by bind.
// Depends on kcl_pkg for status codes.
`timescale 1ns / 1ps

module kcl_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  logic [2:0] st;
  assign st = out_tdata[10:8];

  // A stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // No character without an echo
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("character shown without echo");

  // Remaining ticks only while locked
  a_remain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18:11] != 8'd0 |-> st == kcl_pkg::ST_LOCKED)
    else $error("lock_remaining set outside lockout");

  // Unlock comes from a tick, never from a key
  a_unlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == kcl_pkg::ST_UNLOCKED |-> !out_tuser && out_tdata[18:11] == 8'd0)
    else $error("bad unlock beat");

  // Nothing comes out the cycle after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind keypad_code_lock_top kcl_port_checker u_kcl_port_checker (.*);
